>>> design/lbs_pkg.sv
// shared constants, types and helpers for the linear blend skinning block
`timescale 1ns / 1ps

package lbs_pkg;

    // bone store geometry
    localparam int MAX_BONES   = 128;
    localparam int MAT_ENTRIES = 16;
    localparam int MAT_DIM     = 4;
    localparam int BONE_W      = 7;
    localparam int BONE_AW     = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int ENTRY_W     = 4;

    // influences per vertex; the item carries four
    localparam int INFLUENCES  = 4;
    localparam int FIELD_INF   = 4;
    localparam int INF_W       = (INFLUENCES > 1) ? $clog2(INFLUENCES) : 1;

    // datapath widths
    localparam int COORD_W     = 32;
    localparam int WEIGHT_W    = 16;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int WPROD_W     = COORD_W + WEIGHT_W + 1;
    localparam int ACC_W       = WPROD_W + INF_W + 1;
    localparam int WEIGHT_FRAC = 15;

    // result queue
    localparam int FIFO_DEPTH  = 16;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = FIFO_AW + 1;

    // stream payload layout, lowest bit first
    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 4 * COORD_W;
    localparam int OFS_BONE    = 0;
    localparam int OFS_WHICH   = 7;
    localparam int OFS_ENTRY   = 8;
    localparam int OFS_VALUE   = 12;
    localparam int OFS_PX      = 44;
    localparam int OFS_PY      = 76;
    localparam int OFS_PZ      = 108;
    localparam int OFS_IDX     = 140;
    localparam int OFS_WTS     = 168;
    localparam int IDX_W       = FIELD_INF * BONE_W;
    localparam int WTS_W       = FIELD_INF * WEIGHT_W;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_SKIN = 1'b1
    } cmd_t;

    typedef enum logic
    {
        MAT_IBIND = 1'b0,
        MAT_POSE  = 1'b1
    } mat_sel_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    // control that travels with each influence down the pipeline
    typedef struct packed
    {
        logic                valid;
        logic                first;
        logic                last;
        logic [WEIGHT_W-1:0] weight;
    } ctl_t;

    // clamp a signed value to the 32-bit range
    function automatic coord_t sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi)
        begin
            return coord_t'(hi[COORD_W-1:0]);
        end
        else if (v < lo)
        begin
            return coord_t'(lo[COORD_W-1:0]);
        end
        return coord_t'(v[COORD_W-1:0]);
    endfunction

endpackage

>>> design/lbs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and read-first registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/lbs_xform.sv
// two-stage transform of a point (x, y, z, 1) by a 4x4 q16.16 matrix
`timescale 1ns / 1ps

module lbs_xform
    import lbs_pkg::*;
(
    input  logic   clk,
    input  coord_t vin  [3],
    input  coord_t mat  [MAT_ENTRIES],
    output coord_t vout [MAT_DIM]
);

    logic signed [PROD_W-1:0] prod_reg [3][MAT_DIM];
    coord_t                   trans_reg [MAT_DIM];
    coord_t                   vout_next [MAT_DIM];
    coord_t                   vout_reg  [MAT_DIM];

    // stage a: the nine-plus-three products, translation row held
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < MAT_DIM; c++)
            begin
                prod_reg[r][c] <= vin[r] * mat[r*MAT_DIM + c];
            end
        end
        for (int c = 0; c < MAT_DIM; c++)
        begin
            trans_reg[c] <= mat[3*MAT_DIM + c];
        end
    end

    // stage b: column sum, floor to q16.16, add translation, clamp
    always_comb
    begin
        logic signed [PROD_W+1:0] sum;
        logic signed [PROD_W-15:0] q;
        logic signed [PROD_W-14:0] tot;
        for (int c = 0; c < MAT_DIM; c++)
        begin
            sum = {{2{prod_reg[0][c][PROD_W-1]}}, prod_reg[0][c]}
                + {{2{prod_reg[1][c][PROD_W-1]}}, prod_reg[1][c]}
                + {{2{prod_reg[2][c][PROD_W-1]}}, prod_reg[2][c]};
            q   = sum[PROD_W+1:16];
            tot = {q[PROD_W-15], q}
                + {{(PROD_W-13-COORD_W){trans_reg[c][COORD_W-1]}}, trans_reg[c]};
            vout_next[c] = sat32({{(64-(PROD_W-13)){tot[PROD_W-14]}}, tot});
        end
    end

    always_ff @(posedge clk)
    begin
        vout_reg <= vout_next;
    end

    assign vout = vout_reg;

endmodule

>>> design/linear_blend_skinning.sv
// top level of the four-influence linear blend skinning block
//
// usage:
//   the input stream carries load and skin transactions, tuser selects the
//   kind (0 load one matrix entry, 1 skin one vertex). a load writes one
//   q16.16 entry of a bone's inverse bind or current pose matrix and gives
//   no result. a skin transaction gives one result transaction with the
//   blended x, y, z, w in q16.16, saturated.
//   a skin issues one influence per cycle, each reading a whole matrix of
//   each store from the per-entry bone rams through their single read port;
//   its result passes the ram read, both transforms, the weighting and the
//   accumulator into the queue. s_tready is low while a skin issues all but
//   its last influence (a new transaction is taken with the last one) and
//   while 16 skin transactions are pending (accepted, result not yet taken).
//   results wait in a 16-deep queue, so a stalled receiver blocks the input
//   only once 16 are pending; the arithmetic pipeline itself never stops.
//   reset empties the pipeline and the queue; the matrix stores are not
//   cleared and must be loaded before any bone is used for skinning.
`timescale 1ns / 1ps

module linear_blend_skinning
    import lbs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // bone, which_matrix, entry, entry_value, pos_x, pos_y, pos_z,
    // bone_indices, bone_weights
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_x, out_y, out_z, out_w
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // input field extraction
    cmd_t               in_cmd;
    logic [BONE_W-1:0]  in_bone;
    mat_sel_t           in_which;
    logic [ENTRY_W-1:0] in_entry;
    coord_t             in_value;
    coord_t             in_pos [3];
    logic [IDX_W-1:0]   in_idx;
    logic [WTS_W-1:0]   in_wts;

    assign in_cmd    = cmd_t'(s_tuser[0]);
    assign in_bone   = s_tdata[OFS_BONE +: BONE_W];
    assign in_which  = mat_sel_t'(s_tdata[OFS_WHICH]);
    assign in_entry  = s_tdata[OFS_ENTRY +: ENTRY_W];
    assign in_value  = s_tdata[OFS_VALUE +: COORD_W];
    assign in_pos[0] = s_tdata[OFS_PX +: COORD_W];
    assign in_pos[1] = s_tdata[OFS_PY +: COORD_W];
    assign in_pos[2] = s_tdata[OFS_PZ +: COORD_W];
    assign in_idx    = s_tdata[OFS_IDX +: IDX_W];
    assign in_wts    = s_tdata[OFS_WTS +: WTS_W];

    // handshake
    logic               in_acc;
    logic               load_acc;
    logic               skin_acc;
    logic               out_pop;
    logic               seq_free;
    logic [FIFO_CW-1:0] pend_reg;
    logic [FIFO_CW-1:0] pend_next;

    assign in_acc   = s_tvalid && s_tready;
    assign load_acc = in_acc && (in_cmd == CMD_LOAD);
    assign skin_acc = in_acc && (in_cmd == CMD_SKIN);
    assign s_tready = seq_free && (pend_reg < FIFO_CW'(FIFO_DEPTH));

    // influence sequencer
    logic             busy_reg;
    logic [INF_W-1:0] k_reg;
    coord_t           pos_reg [3];
    logic [IDX_W-1:0] idx_reg;
    logic [WTS_W-1:0] wts_reg;
    logic             k_last;

    assign k_last   = (k_reg == INF_W'(INFLUENCES - 1));
    assign seq_free = !busy_reg || k_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (skin_acc)
        begin
            busy_reg <= 1'b1;
            k_reg    <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !k_last;
            k_reg    <= k_reg + INF_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (skin_acc)
        begin
            pos_reg <= in_pos;
            idx_reg <= in_idx;
            wts_reg <= in_wts;
        end
    end

    // current influence: bone and weight, extras beyond the item carry none
    logic [BONE_W-1:0]   cur_bone;
    logic [WEIGHT_W-1:0] cur_wt;
    logic                cur_inrange;

    always_comb
    begin
        cur_bone = '0;
        cur_wt   = '0;
        for (int k = 0; k < FIELD_INF; k++)
        begin
            if (32'(k_reg) == k)
            begin
                cur_bone = idx_reg[k*BONE_W +: BONE_W];
                cur_wt   = wts_reg[k*WEIGHT_W +: WEIGHT_W];
            end
        end
        cur_inrange = ({1'b0, cur_bone} < (BONE_W+1)'(MAX_BONES));
    end

    // bone matrix stores, one ram per entry and matrix
    coord_t ib_rd   [MAT_ENTRIES];
    coord_t pose_rd [MAT_ENTRIES];
    logic   wr_ok;

    assign wr_ok = load_acc && ({1'b0, in_bone} < (BONE_W+1)'(MAX_BONES));

    for (genvar e = 0; e < MAT_ENTRIES; e++)
    begin : g_store
        lbs_ram #(
            .WIDTH (COORD_W),
            .DEPTH (MAX_BONES)
        ) u_ib_ram (
            .clk   (clk),
            .we    (wr_ok && (in_which == MAT_IBIND) && (in_entry == ENTRY_W'(e))),
            .waddr (in_bone[BONE_AW-1:0]),
            .wdata (in_value),
            .raddr (cur_bone[BONE_AW-1:0]),
            .rdata (ib_rd[e])
        );

        lbs_ram #(
            .WIDTH (COORD_W),
            .DEPTH (MAX_BONES)
        ) u_pose_ram (
            .clk   (clk),
            .we    (wr_ok && (in_which == MAT_POSE) && (in_entry == ENTRY_W'(e))),
            .waddr (in_bone[BONE_AW-1:0]),
            .wdata (in_value),
            .raddr (cur_bone[BONE_AW-1:0]),
            .rdata (pose_rd[e])
        );
    end

    // stage 1: ram data arrives, control and position alongside
    ctl_t   s1_ctl_reg;
    ctl_t   s1_ctl_next;
    coord_t s1_pos_reg [3];

    always_comb
    begin
        s1_ctl_next.valid  = busy_reg;
        s1_ctl_next.first  = (k_reg == '0);
        s1_ctl_next.last   = k_last;
        s1_ctl_next.weight = cur_inrange ? cur_wt : '0;
    end

    always_ff @(posedge clk)
    begin
        s1_pos_reg <= pos_reg;
    end

    // stages 2-3: inverse bind transform
    coord_t local_v [MAT_DIM];
    coord_t pose_s2_reg [MAT_ENTRIES];
    coord_t pose_s3_reg [MAT_ENTRIES];

    lbs_xform u_xform_ib (
        .clk  (clk),
        .vin  (s1_pos_reg),
        .mat  (ib_rd),
        .vout (local_v)
    );

    always_ff @(posedge clk)
    begin
        pose_s2_reg <= pose_rd;
        pose_s3_reg <= pose_s2_reg;
    end

    // stages 4-5: current pose transform, intermediate w dropped
    coord_t local_xyz [3];
    coord_t posed_v   [MAT_DIM];

    assign local_xyz[0] = local_v[0];
    assign local_xyz[1] = local_v[1];
    assign local_xyz[2] = local_v[2];

    lbs_xform u_xform_pose (
        .clk  (clk),
        .vin  (local_xyz),
        .mat  (pose_s3_reg),
        .vout (posed_v)
    );

    // control delay line across the transforms
    ctl_t s2_ctl_reg;
    ctl_t s3_ctl_reg;
    ctl_t s4_ctl_reg;
    ctl_t s5_ctl_reg;
    ctl_t s6_ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            s6_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            s5_ctl_reg <= s4_ctl_reg;
            s6_ctl_reg <= s5_ctl_reg;
        end
    end

    // stage 6: weight each component
    logic signed [WPROD_W-1:0] wprod_reg [MAT_DIM];

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < MAT_DIM; c++)
        begin
            wprod_reg[c] <= posed_v[c] * $signed({1'b0, s5_ctl_reg.weight});
        end
    end

    // stage 7: accumulate influences, floor and clamp on the last one
    logic signed [ACC_W-1:0] acc_reg  [MAT_DIM];
    logic signed [ACC_W-1:0] acc_next [MAT_DIM];
    coord_t                  res_next [MAT_DIM];
    coord_t                  res_reg  [MAT_DIM];
    logic                    res_valid_reg;

    always_comb
    begin
        logic signed [ACC_W-1:0] base;
        for (int c = 0; c < MAT_DIM; c++)
        begin
            base        = s6_ctl_reg.first ? '0 : acc_reg[c];
            acc_next[c] = base
                        + {{(ACC_W-WPROD_W){wprod_reg[c][WPROD_W-1]}}, wprod_reg[c]};
            res_next[c] = sat32({{(64-ACC_W+WEIGHT_FRAC){acc_next[c][ACC_W-1]}},
                                 acc_next[c][ACC_W-1:WEIGHT_FRAC]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (s6_ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (s6_ctl_reg.valid && s6_ctl_reg.last)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= s6_ctl_reg.valid && s6_ctl_reg.last;
        end
    end

    // result queue
    logic [OUT_TDATA_W-1:0] fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg;
    logic [FIFO_AW-1:0]     rd_ptr_reg;
    logic [FIFO_CW-1:0]     fcount_reg;

    always_ff @(posedge clk)
    begin
        if (res_valid_reg)
        begin
            fifo_mem[wr_ptr_reg] <= {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    assign m_tvalid = (fcount_reg != '0);
    assign m_tdata  = fifo_mem[rd_ptr_reg];
    assign out_pop  = m_tvalid && m_tready;

    // pending count: skin transactions accepted whose result is not yet taken
    always_comb
    begin
        pend_next = pend_reg;
        if (skin_acc && !out_pop)
        begin
            pend_next = pend_reg + FIFO_CW'(1);
        end
        else if (!skin_acc && out_pop)
        begin
            pend_next = pend_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcount_reg <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (res_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (res_valid_reg && !out_pop)
            begin
                fcount_reg <= fcount_reg + FIFO_CW'(1);
            end
            else if (!res_valid_reg && out_pop)
            begin
                fcount_reg <= fcount_reg - FIFO_CW'(1);
            end
        end
    end

    // queued results never outnumber pending skin transactions
    a_queue_le_pending : assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= pend_reg)
        else $error("result queue holds more than pending transactions");

    // a push never lands on a full queue
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (fcount_reg < FIFO_CW'(FIFO_DEPTH)) || out_pop)
        else $error("result queue overflow");

    // the sequencer keeps issuing until the last influence
    a_seq_runs : assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !k_last) |=> busy_reg)
        else $error("influence sequence cut short");

    // a result is produced only after a final influence
    a_res_from_last : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $past(s6_ctl_reg.valid && s6_ctl_reg.last))
        else $error("result without a final influence");

    // a skin accept starts a fresh influence sequence
    a_skin_starts : assert property (@(posedge clk) disable iff (!rst_n)
        skin_acc |=> (busy_reg && (k_reg == '0)))
        else $error("skin transaction did not start the sequencer");

endmodule
